>>> rtl/glsp_pkg.sv
// ----------------------------------------------------------------------------
// glsp_pkg
// Shared sizes, codes and types of the grid light spread block.
// ----------------------------------------------------------------------------
package glsp_pkg;

    localparam int GRID_COLS = 64;
    localparam int GRID_ROWS = 64;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CHAIN_LEN = GRID_COLS + 1;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    localparam logic [1:0] CFG_DAYLIGHT = 2'd0;
    localparam logic [1:0] CFG_COLS     = 2'd1;
    localparam logic [1:0] CFG_ROWS     = 2'd2;

    typedef struct packed {
        logic [7:0] adj;
        logic [7:0] far_m1;
        logic [7:0] far;
        logic [7:0] far_p1;
    } t_taps;

    function automatic logic [ADDR_W-1:0] cell_idx(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        logic [31:0] lin;
        lin = 32'(row) * 32'(GRID_COLS) + 32'(col);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

>>> rtl/glsp_ram.sv
// ----------------------------------------------------------------------------
// glsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module glsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/glsp_cell.sv
// ----------------------------------------------------------------------------
// glsp_cell
// One stage of the light chain: holds one level and hands it on.
// ----------------------------------------------------------------------------
module glsp_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic       i_flush,
    input  logic [7:0] i_d,
    output logic [7:0] o_q
);

    logic [7:0] r_q;
    logic [7:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_flush) begin
            n_q = 8'd0;
        end else if (i_shift) begin
            n_q = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

>>> rtl/glsp_chain.sv
// ----------------------------------------------------------------------------
// glsp_chain
// Row of cells holding the last grid row plus one of swept levels.
// ----------------------------------------------------------------------------
module glsp_chain (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic                i_flush,
    input  logic [7:0]          i_d,
    output glsp_pkg::t_taps     o_taps
);

    logic [7:0] w_q [glsp_pkg::CHAIN_LEN];

    for (genvar g = 0; g < glsp_pkg::CHAIN_LEN; g++) begin : g_cell
        glsp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_shift),
            .i_flush (i_flush),
            .i_d     ((g == 0) ? i_d : w_q[(g == 0) ? 0 : g - 1]),
            .o_q     (w_q[g])
        );
    end

    assign o_taps.adj    = w_q[0];
    assign o_taps.far_m1 = w_q[glsp_pkg::GRID_COLS - 2];
    assign o_taps.far    = w_q[glsp_pkg::GRID_COLS - 1];
    assign o_taps.far_p1 = w_q[glsp_pkg::GRID_COLS];

endmodule

>>> rtl/grid_light_spread_core.sv
// ----------------------------------------------------------------------------
// grid_light_spread_core
// Light map over a grid of source levels with chessboard distance decay.
// ----------------------------------------------------------------------------
// Every request gives one result beat on o_strobe, which cannot be stalled.
// Writes and reads are accepted every cycle while busy is low and answer in
// the next cycle. A compute holds busy for two raster sweeps over the in-use
// rows, each row taking all 64 grid columns, plus the gap and drain states,
// and answers in the cycle in which busy falls. The single light map memory
// port pair and the cell chain that carries one grid row set this time. After
// reset a clearing pass holds busy while the light map is zeroed.
module grid_light_spread_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_row,
    input  logic [5:0] i_col,
    input  logic [7:0] i_tile_light,
    output logic       o_strobe,
    output logic [7:0] o_cell_light,
    output logic       o_is_read_reply,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_FWD   = 6'b000100,
        S_GAP   = 6'b001000,
        S_BWD   = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    localparam int COL_W = glsp_pkg::COL_W;
    localparam int ROW_W = glsp_pkg::ROW_W;
    localparam int ADDR_W = glsp_pkg::ADDR_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(glsp_pkg::GRID_COLS - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(glsp_pkg::CELLS - 1);

    t_state r_state, n_state;
    logic [7:0] r_daylight;
    logic [6:0] r_cols, r_rows;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic r_p_valid, n_p_valid, r_p_fwd, n_p_fwd;
    logic [ROW_W-1:0] r_p_row;
    logic [COL_W-1:0] r_p_col;
    logic r_rsp_valid, n_rsp_valid, r_rsp_read, n_rsp_read, r_rsp_inside, n_rsp_inside;

    logic w_accept, w_flush, w_inside, w_inreg;
    logic [31:0] w_req_lin, w_w, w_h;
    logic [COL_W:0] w_w_n;
    logic [ROW_W:0] w_h_n;
    logic [7:0] w_src_rdata, w_lm_rdata, w_cur, w_new, w_push;
    logic [7:0] w_m0, w_m1, w_m2, w_m3, w_ma, w_mb, w_m, w_cand;
    logic w_lm_we;
    logic [ADDR_W-1:0] w_lm_waddr, w_lm_raddr, w_src_raddr, w_req_idx, w_p_idx;
    logic [7:0] w_lm_wdata;
    logic w_c_gt0, w_c_last, w_r_gt0, w_r_last;
    glsp_pkg::t_taps w_taps;

    assign w_accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_inside = (32'(i_row) < 32'(glsp_pkg::GRID_ROWS))
                   && (32'(i_col) < 32'(glsp_pkg::GRID_COLS));
    assign w_req_lin = 32'(i_row) * 32'(glsp_pkg::GRID_COLS) + 32'(i_col);
    assign w_req_idx = w_req_lin[ADDR_W-1:0];

    assign w_w = (r_cols == 7'd0) ? 32'd1
               : (32'(r_cols) > 32'(glsp_pkg::GRID_COLS)) ? 32'(glsp_pkg::GRID_COLS)
               : 32'(r_cols);
    assign w_h = (r_rows == 7'd0) ? 32'd1
               : (32'(r_rows) > 32'(glsp_pkg::GRID_ROWS)) ? 32'(glsp_pkg::GRID_ROWS)
               : 32'(r_rows);
    assign w_w_n = w_w[COL_W:0];
    assign w_h_n = w_h[ROW_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_daylight <= 8'd0;
            r_cols     <= 7'd64;
            r_rows     <= 7'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                glsp_pkg::CFG_DAYLIGHT: r_daylight <= i_cfg_data;
                glsp_pkg::CFG_COLS:     r_cols     <= i_cfg_data[6:0];
                glsp_pkg::CFG_ROWS:     r_rows     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_row        = r_row;
        n_col        = r_col;
        n_p_valid    = 1'b0;
        n_p_fwd      = r_p_fwd;
        n_rsp_valid  = 1'b0;
        n_rsp_read   = 1'b0;
        n_rsp_inside = r_rsp_inside;
        w_flush      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == ADDR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == glsp_pkg::REQ_COMPUTE) begin
                        n_state = S_FWD;
                        n_row   = '0;
                        n_col   = '0;
                        w_flush = 1'b1;
                    end else begin
                        n_rsp_valid  = 1'b1;
                        n_rsp_read   = (i_req_type == glsp_pkg::REQ_READ);
                        n_rsp_inside = w_inside;
                    end
                end
            end
            S_FWD: begin
                n_p_valid = 1'b1;
                n_p_fwd   = 1'b1;
                n_col     = r_col + 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                    if ({1'b0, r_row} == w_h_n - 1'b1) begin
                        n_state = S_GAP;
                    end
                end
            end
            S_GAP: begin
                w_flush = 1'b1;
                n_row   = ROW_W'(w_h_n - 1'b1);
                n_col   = COL_LAST;
                n_state = S_BWD;
            end
            S_BWD: begin
                n_p_valid = 1'b1;
                n_p_fwd   = 1'b0;
                n_col     = r_col - 1'b1;
                if (r_col == '0) begin
                    n_col = COL_LAST;
                    n_row = r_row - 1'b1;
                    if (r_row == '0) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_p_valid   <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_rsp_read  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_p_valid   <= n_p_valid;
            r_rsp_valid <= n_rsp_valid;
            r_rsp_read  <= n_rsp_read;
        end
        r_row        <= n_row;
        r_col        <= n_col;
        r_p_fwd      <= n_p_fwd;
        r_p_row      <= r_row;
        r_p_col      <= r_col;
        r_rsp_inside <= n_rsp_inside;
    end

    assign w_c_gt0  = (r_p_col != '0);
    assign w_c_last = !({1'b0, r_p_col} + 1'b1 < w_w_n);
    assign w_r_gt0  = (r_p_row != '0);
    assign w_r_last = !({1'b0, r_p_row} + 1'b1 < w_h_n);
    assign w_inreg  = ({1'b0, r_p_col} < w_w_n);

    always_comb begin
        if (r_p_fwd) begin
            w_cur = w_src_rdata;
            w_m0  = w_c_gt0 ? w_taps.adj : 8'd0;
            w_m1  = (w_r_gt0 && !w_c_last) ? w_taps.far_m1 : 8'd0;
            w_m2  = w_r_gt0 ? w_taps.far : 8'd0;
            w_m3  = (w_r_gt0 && w_c_gt0) ? w_taps.far_p1 : 8'd0;
        end else begin
            w_cur = w_lm_rdata;
            w_m0  = !w_c_last ? w_taps.adj : 8'd0;
            w_m1  = (!w_r_last && w_c_gt0) ? w_taps.far_m1 : 8'd0;
            w_m2  = !w_r_last ? w_taps.far : 8'd0;
            w_m3  = (!w_r_last && !w_c_last) ? w_taps.far_p1 : 8'd0;
        end
        w_ma   = (w_m0 > w_m1) ? w_m0 : w_m1;
        w_mb   = (w_m2 > w_m3) ? w_m2 : w_m3;
        w_m    = (w_ma > w_mb) ? w_ma : w_mb;
        w_cand = (w_m == 8'd0) ? 8'd0 : w_m - 8'd1;
        w_new  = (w_cand > w_cur) ? w_cand : w_cur;
        w_push = w_inreg ? w_new : 8'd0;
    end

    glsp_chain u_chain (
        .i_clk   (i_clk),
        .i_shift (r_p_valid),
        .i_flush (w_flush),
        .i_d     (w_push),
        .o_taps  (w_taps)
    );

    assign w_p_idx     = glsp_pkg::cell_idx(r_p_row, r_p_col);
    assign w_src_raddr = glsp_pkg::cell_idx(r_row, r_col);
    assign w_lm_raddr  = (r_state == S_BWD) ? glsp_pkg::cell_idx(r_row, r_col) : w_req_idx;

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_lm_we    = 1'b1;
            w_lm_waddr = r_clr;
            w_lm_wdata = 8'd0;
        end else begin
            w_lm_we    = r_p_valid && w_inreg;
            w_lm_waddr = w_p_idx;
            w_lm_wdata = w_new;
        end
    end

    glsp_ram #(.WIDTH(8), .DEPTH(glsp_pkg::CELLS)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_req_type == glsp_pkg::REQ_WRITE) && w_inside),
        .i_waddr (w_req_idx),
        .i_wdata (i_tile_light),
        .i_raddr (w_src_raddr),
        .o_rdata (w_src_rdata)
    );

    glsp_ram #(.WIDTH(8), .DEPTH(glsp_pkg::CELLS)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_lm_we),
        .i_waddr (w_lm_waddr),
        .i_wdata (w_lm_wdata),
        .i_raddr (w_lm_raddr),
        .o_rdata (w_lm_rdata)
    );

    assign o_strobe        = r_rsp_valid;
    assign o_is_read_reply = r_rsp_valid && r_rsp_read;
    assign o_cell_light    = !(r_rsp_valid && r_rsp_read) ? 8'd0
                           : (r_rsp_inside && (w_lm_rdata > r_daylight)) ? w_lm_rdata
                           : r_daylight;

endmodule
